FILE: rtl/ipid_pkg.sv
`default_nettype none

package ipid_pkg;

  localparam int GAIN_W    = 24;
  localparam int CA_W      = GAIN_W + 2;
  localparam int CB_W      = GAIN_W + 3;
  localparam int CFG_IDX_W = 3;

  localparam logic [CFG_IDX_W-1:0] REG_REFERENCE = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_KP        = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_KI_TS     = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_KD_TD     = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_MAX_LIMIT = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_MIN_LIMIT = 3'd5;

  typedef struct packed {
    logic signed [CA_W-1:0]   ca;
    logic signed [CB_W-1:0]   cb;
    logic signed [GAIN_W-1:0] cc;
  } coef_t;

endpackage

`default_nettype wire

FILE: rtl/ipid_cfg.sv
`default_nettype none

module ipid_cfg #(
  parameter int SAMPLE_WIDTH = 16,
  parameter int DATA_W       = 24
) (
  input  wire logic                           clk,
  input  wire logic                           rst_n,
  input  wire logic                           wr_en,
  input  wire logic [ipid_pkg::CFG_IDX_W-1:0] wr_index,
  input  wire logic [DATA_W-1:0]              wr_data,
  output ipid_pkg::coef_t                     coef,
  output logic [SAMPLE_WIDTH-1:0]             reference,
  output logic [SAMPLE_WIDTH-1:0]             max_limit,
  output logic [SAMPLE_WIDTH-1:0]             min_limit
);
  import ipid_pkg::*;

  logic [SAMPLE_WIDTH-1:0] reference_r;
  logic [SAMPLE_WIDTH-1:0] max_limit_r;
  logic [SAMPLE_WIDTH-1:0] min_limit_r;
  logic [GAIN_W-1:0]       kp_r;
  logic [GAIN_W-1:0]       ki_ts_r;
  logic [GAIN_W-1:0]       kd_td_r;
  coef_t                   coef_r;
  coef_t                   coef_nxt;

  always_comb begin
    coef_nxt.ca = CA_W'($signed(kp_r)) + CA_W'($signed(ki_ts_r)) + CA_W'($signed(kd_td_r));
    coef_nxt.cb = -(CB_W'($signed(kp_r)) + (CB_W'($signed(kd_td_r)) <<< 1));
    coef_nxt.cc = $signed(kd_td_r);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      reference_r <= '0;
      kp_r        <= '0;
      ki_ts_r     <= '0;
      kd_td_r     <= '0;
      max_limit_r <= {1'b0, {(SAMPLE_WIDTH-1){1'b1}}};
      min_limit_r <= {1'b1, {(SAMPLE_WIDTH-1){1'b0}}};
      coef_r      <= '0;
    end else begin
      coef_r <= coef_nxt;
      if (wr_en) begin
        case (wr_index)
          REG_REFERENCE: reference_r <= wr_data[SAMPLE_WIDTH-1:0];
          REG_KP:        kp_r        <= wr_data[GAIN_W-1:0];
          REG_KI_TS:     ki_ts_r     <= wr_data[GAIN_W-1:0];
          REG_KD_TD:     kd_td_r     <= wr_data[GAIN_W-1:0];
          REG_MAX_LIMIT: max_limit_r <= wr_data[SAMPLE_WIDTH-1:0];
          REG_MIN_LIMIT: min_limit_r <= wr_data[SAMPLE_WIDTH-1:0];
          default: ;
        endcase
      end
    end
  end

  assign coef      = coef_r;
  assign reference = reference_r;
  assign max_limit = max_limit_r;
  assign min_limit = min_limit_r;

endmodule

`default_nettype wire

FILE: rtl/ipid_core.sv
`default_nettype none

module ipid_core #(
  parameter int SAMPLE_WIDTH   = 16,
  parameter int GAIN_FRAC_BITS = 16
) (
  input  wire logic                    clk,
  input  wire logic                    rst_n,
  input  wire logic                    in_valid,
  output logic                         in_ready,
  input  wire logic                    in_clear,
  input  wire logic [SAMPLE_WIDTH-1:0] in_meas,
  input  wire ipid_pkg::coef_t         coef,
  input  wire logic [SAMPLE_WIDTH-1:0] reference,
  input  wire logic [SAMPLE_WIDTH-1:0] max_limit,
  input  wire logic [SAMPLE_WIDTH-1:0] min_limit,
  output logic                         out_valid,
  input  wire logic                    out_ready,
  output logic [SAMPLE_WIDTH-1:0]      out_drive
);
  import ipid_pkg::*;

  localparam int EW    = SAMPLE_WIDTH + 1;
  localparam int P_W   = CB_W + EW;
  localparam int ACC_W = P_W + 2;
  localparam int U_W   = ACC_W + 1;

  logic                    s_valid_r;
  logic                    s_clear_r;
  logic [SAMPLE_WIDTH-1:0] s_meas_r;
  logic                    out_valid_r;
  logic [SAMPLE_WIDTH-1:0] drive_r;
  logic [EW-1:0]           last_error_r;
  logic [EW-1:0]           older_error_r;
  logic [SAMPLE_WIDTH-1:0] last_drive_r;

  logic                    advance;
  logic signed [EW-1:0]    err_nxt;
  logic signed [P_W-1:0]   prod_a;
  logic signed [P_W-1:0]   prod_b;
  logic signed [P_W-1:0]   prod_c;
  logic signed [ACC_W-1:0] acc;
  logic signed [U_W-1:0]   u_raw;
  logic signed [U_W-1:0]   hi_ext;
  logic signed [U_W-1:0]   lo_ext;
  logic signed [U_W-1:0]   u_hi;
  logic signed [U_W-1:0]   u_clamp;
  logic [SAMPLE_WIDTH-1:0] drive_nxt;

  assign advance  = !out_valid_r || out_ready;
  assign in_ready = !s_valid_r || advance;

  always_comb begin
    err_nxt = EW'($signed(reference)) - EW'($signed(s_meas_r));
    prod_a  = P_W'(coef.ca) * P_W'(err_nxt);
    prod_b  = P_W'(coef.cb) * P_W'($signed(last_error_r));
    prod_c  = P_W'(coef.cc) * P_W'($signed(older_error_r));
    acc     = ACC_W'(prod_a) + ACC_W'(prod_b) + ACC_W'(prod_c);
    u_raw   = U_W'($signed(last_drive_r)) + U_W'(acc >>> GAIN_FRAC_BITS);
    hi_ext  = U_W'($signed(max_limit));
    lo_ext  = U_W'($signed(min_limit));
    u_hi    = (u_raw > hi_ext) ? hi_ext : u_raw;
    u_clamp = (u_hi < lo_ext) ? lo_ext : u_hi;
    drive_nxt = s_clear_r ? '0 : u_clamp[SAMPLE_WIDTH-1:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s_valid_r     <= 1'b0;
      out_valid_r   <= 1'b0;
      last_error_r  <= '0;
      older_error_r <= '0;
      last_drive_r  <= '0;
    end else begin
      if (in_ready) begin
        s_valid_r <= in_valid;
      end
      if (advance) begin
        out_valid_r <= s_valid_r;
        if (s_valid_r) begin
          last_drive_r <= drive_nxt;
          if (s_clear_r) begin
            last_error_r  <= '0;
            older_error_r <= '0;
          end else begin
            last_error_r  <= err_nxt;
            older_error_r <= last_error_r;
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      s_clear_r <= in_clear;
      s_meas_r  <= in_meas;
    end
    if (advance && s_valid_r) begin
      drive_r <= drive_nxt;
    end
  end

  assign out_valid = out_valid_r;
  assign out_drive = drive_r;

endmodule

`default_nettype wire

FILE: rtl/incremental_pid_controller.sv
// Velocity-form PID controller with output clamp.
// Input stream: in_tuser is the request kind (0 = measurement sample,
// 1 = clear state), in_tdata carries the signed measurement.
// Output stream: out_tdata carries the signed clamped drive, one per request.
// Config port: cfg_index selects reference, kp, ki_ts, kd_td, max_limit,
// min_limit (0 to 5); write only while no request is in flight.
// Each sample computes u = u1 + (a*e + b*e1 + c*e2) >>> GAIN_FRAC_BITS,
// clamps it to the limits and keeps the result as the next u1.
// From input accept to output valid the path is an input register,
// one pass of three parallel multiplies, a sum and the clamp, then the
// result register. Throughput is one request per cycle while out_tready
// is high, set by the loop through the error and drive history.
// Reset clears the history and out_tvalid, sets gains and reference to 0
// and the limits to the full sample range.
// A stalled receiver holds out_tdata; one more request may still enter the
// input register, after which in_tready drops until the result is taken.
`default_nettype none

module incremental_pid_controller #(
  parameter int SAMPLE_WIDTH   = 16,
  parameter int GAIN_FRAC_BITS = 16
) (
  input  wire logic                                clk,
  input  wire logic                                rst_n,
  input  wire logic                                in_tvalid,
  output logic                                     in_tready,
  // [0] req_type
  input  wire logic                                in_tuser,
  // [SAMPLE_WIDTH-1:0] measurement, zero padded to bytes
  input  wire logic [((SAMPLE_WIDTH+7)/8)*8-1:0]   in_tdata,
  output logic                                     out_tvalid,
  input  wire logic                                out_tready,
  // [SAMPLE_WIDTH-1:0] drive, zero padded to bytes
  output logic [((SAMPLE_WIDTH+7)/8)*8-1:0]        out_tdata,
  input  wire logic                                cfg_valid,
  output logic                                     cfg_ready,
  input  wire logic [ipid_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  wire logic [((SAMPLE_WIDTH > ipid_pkg::GAIN_W) ?
                      SAMPLE_WIDTH : ipid_pkg::GAIN_W)-1:0] cfg_data
);
  import ipid_pkg::*;

  localparam int TDATA_W = ((SAMPLE_WIDTH + 7) / 8) * 8;
  localparam int DATA_W  = (SAMPLE_WIDTH > GAIN_W) ? SAMPLE_WIDTH : GAIN_W;

  coef_t                   coef;
  logic [SAMPLE_WIDTH-1:0] reference;
  logic [SAMPLE_WIDTH-1:0] max_limit;
  logic [SAMPLE_WIDTH-1:0] min_limit;
  logic [SAMPLE_WIDTH-1:0] drive;

  assign cfg_ready = 1'b1;

  ipid_cfg #(
    .SAMPLE_WIDTH(SAMPLE_WIDTH),
    .DATA_W      (DATA_W)
  ) u_cfg (
    .clk      (clk),
    .rst_n    (rst_n),
    .wr_en    (cfg_valid && cfg_ready),
    .wr_index (cfg_index),
    .wr_data  (cfg_data),
    .coef     (coef),
    .reference(reference),
    .max_limit(max_limit),
    .min_limit(min_limit)
  );

  ipid_core #(
    .SAMPLE_WIDTH  (SAMPLE_WIDTH),
    .GAIN_FRAC_BITS(GAIN_FRAC_BITS)
  ) u_core (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_tvalid),
    .in_ready (in_tready),
    .in_clear (in_tuser),
    .in_meas  (in_tdata[SAMPLE_WIDTH-1:0]),
    .coef     (coef),
    .reference(reference),
    .max_limit(max_limit),
    .min_limit(min_limit),
    .out_valid(out_tvalid),
    .out_ready(out_tready),
    .out_drive(drive)
  );

  assign out_tdata = TDATA_W'(drive);

endmodule

`default_nettype wire
